@@ hdl/efb_pkg.sv @@
// ============================================================================
// efb_pkg
// Shared types and constants for the feedback echo filter.
// ============================================================================
`default_nettype none

package efb_pkg;

    // History depth; must be a power of two so the ring index wraps by itself
    localparam int MAX_DELAY   = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 32;

    localparam int IDX_W   = $clog2(MAX_DELAY);
    localparam int CNT_W   = IDX_W + 1;
    localparam int DELAY_W = 13;
    localparam int GAIN_W  = 18;
    localparam int CFG_W   = 18;
    localparam int PROD_W  = SAMPLE_BITS + GAIN_W;
    localparam int SH_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W   = ((SH_W > SAMPLE_BITS) ? SH_W : SAMPLE_BITS) + 1;

    // Register map
    localparam logic REG_ECHO_DELAY = 1'b0;
    localparam logic REG_ECHO_GAIN  = 1'b1;

    localparam logic [DELAY_W-1:0]      DELAY_RESET = DELAY_W'(1200);
    localparam logic signed [GAIN_W-1:0] GAIN_RESET = GAIN_W'(19660);

    // Source of the feedback operand
    typedef enum logic [1:0] {
        FB_ZERO,
        FB_INPUT,
        FB_MEM,
        FB_FWD
    } fb_sel_t;

    // Per-stage control carried along the pipeline
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] slot;
    } stage_t;

endpackage

`default_nettype wire

@@ hdl/efb_hist_ram.sv @@
// ============================================================================
// efb_hist_ram
// Output history ring: one write port, one registered read port.
// ============================================================================
`default_nettype none

module efb_hist_ram (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [efb_pkg::IDX_W-1:0]          waddr,
    input  wire logic signed [efb_pkg::SAMPLE_BITS-1:0] wdata,
    input  wire logic                               re,
    input  wire logic [efb_pkg::IDX_W-1:0]          raddr,
    output logic signed [efb_pkg::SAMPLE_BITS-1:0]  rdata
);
    import efb_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_DELAY];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/efb_mac.sv @@
// ============================================================================
// efb_mac
// Feedback multiply stage and saturating add stage.
// ============================================================================
`default_nettype none

module efb_mac (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire efb_pkg::stage_t                        b_ctl,
    input  wire efb_pkg::fb_sel_t                       b_sel,
    input  wire logic signed [efb_pkg::SAMPLE_BITS-1:0] b_x,
    input  wire logic signed [efb_pkg::SAMPLE_BITS-1:0] mem_rdata,
    input  wire logic signed [efb_pkg::SAMPLE_BITS-1:0] fwd_data,
    input  wire logic signed [efb_pkg::GAIN_W-1:0]      gain,
    output efb_pkg::stage_t                             c_ctl,
    output logic signed [efb_pkg::SAMPLE_BITS-1:0]      y
);
    import efb_pkg::*;

    logic signed [SAMPLE_BITS-1:0] fb_op;
    logic signed [PROD_W-1:0]      prod_next;
    stage_t                        c_ctl_reg;
    logic signed [SAMPLE_BITS-1:0] c_x_reg;
    logic signed [PROD_W-1:0]      c_prod_reg;
    logic signed [SH_W-1:0]        shifted;
    logic signed [SUM_W-1:0]       sum;
    logic                          ovf;

    // Feedback operand select and product
    always_comb
    begin
        case (b_sel)
            FB_ZERO:  fb_op = '0;
            FB_INPUT: fb_op = b_x;
            FB_MEM:   fb_op = mem_rdata;
            FB_FWD:   fb_op = fwd_data;
            default:  fb_op = '0;
        endcase
        prod_next = PROD_W'(fb_op) * PROD_W'(gain);
    end

    // Product register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctl_reg <= '0;
        end
        else if (en)
        begin
            c_ctl_reg <= b_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_x_reg    <= b_x;
            c_prod_reg <= prod_next;
        end
    end

    // Floor shift, add, saturate
    always_comb
    begin
        shifted = SH_W'(c_prod_reg >>> FRAC_BITS);
        sum     = SUM_W'(c_x_reg) + SUM_W'(shifted);
        ovf     = (sum[SUM_W-1:SAMPLE_BITS-1] != '0) && (sum[SUM_W-1:SAMPLE_BITS-1] != '1);
        if (ovf)
        begin
            y = sum[SUM_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                             : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else
        begin
            y = sum[SAMPLE_BITS-1:0];
        end
    end

    assign c_ctl = c_ctl_reg;

endmodule

`default_nettype wire

@@ hdl/feedback_echo_filter.sv @@
// ============================================================================
// feedback_echo_filter
// Recursive echo: y[n] = sat(x[n] + floor(y[n-d] * gain / 2^FRAC_BITS)).
// ============================================================================
// Usage:
//   Input channel in_valid/in_stall carries sample_in and restart; output
//   channel out_valid/out_stall carries sample_out, one item out per item in,
//   in order. echo_delay and echo_gain are written through cfg_write,
//   cfg_index, cfg_data while the filter is idle.
// Path: from input accept to sample_out valid: history read into stage B,
//   multiply into stage C, add/saturate into the output register.
// Throughput: one item per cycle while the output is not stalled, for
//   echo_delay >= 2 or echo_delay == 0. With echo_delay == 1 an item needs
//   the result of the item just ahead while it is still in the multiplier,
//   so it is held by in_stall until that result is in stage C and forwarded;
//   the limit is the recursion: the add result comes after the multiply needs it.
// Reset: registers return to delay 1200 and gain 19660, the ring index and
//   sample count clear; the history RAM is not cleared and its data is only
//   used once enough samples have been written.
// Stall: when out_stall holds a waiting result, the whole pipeline freezes
//   and in_stall rises; nothing is lost or repeated.
// ============================================================================
`default_nettype none

module feedback_echo_filter (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_write,
    input  wire logic                                   cfg_index,
    input  wire logic [efb_pkg::CFG_W-1:0]              cfg_data,
    // input channel
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [efb_pkg::SAMPLE_BITS-1:0] sample_in,
    input  wire logic                                   restart,
    // output channel
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [efb_pkg::SAMPLE_BITS-1:0]      sample_out
);
    import efb_pkg::*;

    // Configuration registers
    logic [DELAY_W-1:0]        echo_delay_reg;
    logic signed [GAIN_W-1:0]  echo_gain_reg;

    // Sequencing state
    logic [IDX_W-1:0]          write_index_reg;
    logic [CNT_W-1:0]          seen_reg;
    logic [CNT_W-1:0]          seen_base;
    logic [CNT_W-1:0]          seen_next;
    logic [CNT_W-1:0]          d_eff;
    logic [IDX_W-1:0]          rd_idx;
    logic                      need_hist;
    logic                      hazard;
    logic                      en;
    logic                      accept;
    fb_sel_t                   sel_in;

    // Stage B registers
    stage_t                    b_ctl_reg;
    fb_sel_t                   b_sel_reg;
    logic signed [SAMPLE_BITS-1:0] b_x_reg;
    logic signed [SAMPLE_BITS-1:0] fwd_data_reg;

    // Stage C / output
    stage_t                    c_ctl;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] mem_rdata;
    logic                      out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_delay_reg <= DELAY_RESET;
            echo_gain_reg  <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ECHO_DELAY: echo_delay_reg <= cfg_data[DELAY_W-1:0];
                REG_ECHO_GAIN:  echo_gain_reg  <= cfg_data[GAIN_W-1:0];
                default:        echo_delay_reg <= echo_delay_reg;
            endcase
        end
    end

    // Pipeline advances unless a result waits on a stalled receiver
    assign en = !(out_valid_reg && out_stall);

    // Feedback source decision for the incoming item
    always_comb
    begin
        d_eff     = (32'(echo_delay_reg) > MAX_DELAY) ? CNT_W'(MAX_DELAY)
                                                      : CNT_W'(echo_delay_reg);
        seen_base = restart ? '0 : seen_reg;
        seen_next = (32'(seen_base) < MAX_DELAY) ? seen_base + 1'b1 : seen_base;
        rd_idx    = write_index_reg - d_eff[IDX_W-1:0];
        need_hist = (seen_base >= d_eff) && (d_eff != '0);
        if (d_eff == '0)
        begin
            sel_in = FB_INPUT;
        end
        else if (!need_hist)
        begin
            sel_in = FB_ZERO;
        end
        else if (c_ctl.valid && (c_ctl.slot == rd_idx))
        begin
            sel_in = FB_FWD;
        end
        else
        begin
            sel_in = FB_MEM;
        end
        // Entry still being multiplied: wait until it moves into C, then forward from C
        hazard = need_hist && b_ctl_reg.valid && (b_ctl_reg.slot == rd_idx);
    end

    assign in_stall = !en || hazard;
    assign accept   = in_valid && !in_stall;

    // Ring index and sample count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            seen_reg        <= '0;
        end
        else if (accept)
        begin
            write_index_reg <= write_index_reg + 1'b1;
            seen_reg        <= seen_next;
        end
    end

    // Stage B control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctl_reg <= '0;
            b_sel_reg <= FB_ZERO;
        end
        else if (en)
        begin
            b_ctl_reg.valid <= accept;
            b_ctl_reg.slot  <= write_index_reg;
            b_sel_reg       <= sel_in;
        end
    end

    // Stage B payload; C result captured on every accept, used when it lands on the entry being read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_x_reg      <= sample_in;
            fwd_data_reg <= y;
        end
    end

    efb_hist_ram u_ram (
        .clk   (clk),
        .we    (en && c_ctl.valid),
        .waddr (c_ctl.slot),
        .wdata (y),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (mem_rdata)
    );

    efb_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .b_ctl     (b_ctl_reg),
        .b_sel     (b_sel_reg),
        .b_x       (b_x_reg),
        .mem_rdata (mem_rdata),
        .fwd_data  (fwd_data_reg),
        .gain      (echo_gain_reg),
        .c_ctl     (c_ctl),
        .y         (y)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && c_ctl.valid)
        begin
            out_data_reg <= y;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // Checks
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(seen_reg) <= MAX_DELAY)
        else $error("sample count above history depth");

    a_no_b_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && need_hist && b_ctl_reg.valid) |-> (b_ctl_reg.slot != rd_idx))
        else $error("history read of an entry still in the multiplier");

    a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sel_in == FB_FWD) |-> (c_ctl.valid && en))
        else $error("forward selected without a result being written");

endmodule

`default_nettype wire
